@@ hdl/ppgp_pkg.sv @@
`timescale 1ns / 1ps

package ppgp_pkg;

    // register map
    localparam logic [2:0] REG_ROT0      = 3'd0;
    localparam logic [2:0] REG_ROT1      = 3'd1;
    localparam logic [2:0] REG_ROT2      = 3'd2;
    localparam logic [2:0] REG_T_W2C     = 3'd3;
    localparam logic [2:0] REG_T_C2W     = 3'd4;
    localparam logic [2:0] REG_FOCAL     = 3'd5;
    localparam logic [2:0] REG_IMG_CTR   = 3'd6;

    // word kinds
    localparam logic KIND_GROUND = 1'b0;
    localparam logic KIND_IMAGE  = 1'b1;

    localparam int CFG_W   = 60;
    localparam int ROT_W   = 54;
    localparam int TRN_W   = 60;
    localparam int CAM_W   = 40;

    localparam logic [ROT_W-1:0] ROT0_RST  = 54'h10_0000_0000_0000;
    localparam logic [ROT_W-1:0] ROT1_RST  = 54'h00_0004_0000_0000;
    localparam logic [ROT_W-1:0] ROT2_RST  = 54'h00_0000_0001_0000;
    localparam logic [CAM_W-1:0] FOCAL_RST = 40'h1F400_1F400;
    localparam logic [CAM_W-1:0] CTR_RST   = 40'h14000_0F000;

    // divider geometry: numerator and divisor magnitudes, quotient bits
    localparam int NUM_W  = 85;
    localparam int DEN_W  = 65;
    localparam int QUOT_W = 41;

    localparam logic signed [42:0] GND_MAX = 43'sd524287;
    localparam logic signed [42:0] GND_MIN = -43'sd524288;

    typedef struct packed {
        logic kind;
        logic ok;
        logic neg;
    } side_t;

endpackage

@@ hdl/ppgp_div.sv @@
`timescale 1ns / 1ps

// pipelined restoring divider, one quotient bit per stage
module ppgp_div (
    input  logic                        clk,
    input  logic                        rst_n,
    input  logic                        adv,
    input  logic                        in_vld,
    input  logic [ppgp_pkg::NUM_W-1:0]  num,
    input  logic [ppgp_pkg::DEN_W-1:0]  den,
    input  ppgp_pkg::side_t             side_in,
    output logic                        out_vld,
    output logic [ppgp_pkg::QUOT_W-1:0] quot,
    output logic                        ovf,
    output ppgp_pkg::side_t             side_out
);

    localparam int QB = ppgp_pkg::QUOT_W;
    localparam int NW = ppgp_pkg::NUM_W;
    localparam int DW = ppgp_pkg::DEN_W;
    localparam int HW = NW - QB;

    logic                  vld_reg  [QB+1];
    logic [DW-1:0]         rem_reg  [QB+1];
    logic [QB-1:0]         low_reg  [QB+1];
    logic [QB-1:0]         q_reg    [QB+1];
    logic [DW-1:0]         den_reg  [QB+1];
    logic                  ovf_reg  [QB+1];
    ppgp_pkg::side_t       side_reg [QB+1];

    logic [DW-1:0] hi_ext;

    // top part of the numerator; quotient does not fit if it reaches den
    assign hi_ext = {{(DW-HW){1'b0}}, num[NW-1:QB]};

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            vld_reg[0] <= 1'b0;
        end
        else if (adv)
        begin
            vld_reg[0] <= in_vld;
        end
    end

    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            rem_reg[0]  <= hi_ext;
            low_reg[0]  <= num[QB-1:0];
            q_reg[0]    <= '0;
            den_reg[0]  <= den;
            ovf_reg[0]  <= (hi_ext >= den);
            side_reg[0] <= side_in;
        end
    end

    for (genvar k = 1; k <= QB; k++)
    begin : g_stage
        logic [DW:0] sh;
        logic [DW:0] diff;
        logic        ge;

        assign sh   = {rem_reg[k-1], low_reg[k-1][QB-1]};
        assign diff = sh - {1'b0, den_reg[k-1]};
        assign ge   = (sh >= {1'b0, den_reg[k-1]});

        always_ff @(posedge clk or negedge rst_n)
        begin
            if (!rst_n)
            begin
                vld_reg[k] <= 1'b0;
            end
            else if (adv)
            begin
                vld_reg[k] <= vld_reg[k-1];
            end
        end

        always_ff @(posedge clk)
        begin
            if (adv)
            begin
                rem_reg[k]  <= ge ? diff[DW-1:0] : sh[DW-1:0];
                low_reg[k]  <= {low_reg[k-1][QB-2:0], 1'b0};
                q_reg[k]    <= {q_reg[k-1][QB-2:0], ge};
                den_reg[k]  <= den_reg[k-1];
                ovf_reg[k]  <= ovf_reg[k-1];
                side_reg[k] <= side_reg[k-1];
            end
        end
    end

    assign out_vld  = vld_reg[QB];
    assign quot     = q_reg[QB];
    assign ovf      = ovf_reg[QB];
    assign side_out = side_reg[QB];

endmodule

@@ hdl/pinhole_ground_plane_projection.sv @@
`timescale 1ns / 1ps

// Pinhole camera projection against the ground plane z = 0. Each input word is
// either a pixel to be cast onto the ground (kind 0, gives ground_x/ground_y in
// Q8.12) or a world point to be projected into the image (kind 1, gives
// image_x/image_y truncated toward zero). One word is taken per clock unless
// held, and one result word comes out per input word, in order, through eight
// arithmetic stages (normalize, rotate, split 66-bit products, form the ray or
// camera coordinates, take magnitudes, scale by camera height), a 42-stage
// bit-per-stage divider pair (x and y in parallel), and the output register. The
// whole pipe holds when a finished word is stalled at the output, so in_stall
// follows out_valid && out_stall. valid_res is low (and all fields zero) when
// the ray is parallel to the ground, a focal length is zero in kind 0, or the
// point sits at zero depth. Quotients clamp to +-2^40 before the final
// saturation to the field ranges. Configuration (cfg_we/cfg_index/cfg_data) must
// be written only while no word is in flight; the block does not enforce it.
module pinhole_ground_plane_projection #(
    parameter int PIXEL_BITS = 13
) (
    input  logic                          clk,
    input  logic                          rst_n,

    input  logic                          cfg_we,
    input  logic [2:0]                    cfg_index,
    input  logic [ppgp_pkg::CFG_W-1:0]    cfg_data,

    input  logic                          in_valid,
    output logic                          in_stall,
    input  logic                          kind,
    input  logic signed [PIXEL_BITS-1:0]  pixel_x,
    input  logic signed [PIXEL_BITS-1:0]  pixel_y,
    input  logic signed [19:0]            world_x,
    input  logic signed [19:0]            world_y,
    input  logic signed [19:0]            world_z,

    output logic                          out_valid,
    input  logic                          out_stall,
    output logic signed [19:0]            ground_x,
    output logic signed [19:0]            ground_y,
    output logic signed [PIXEL_BITS-1:0]  image_x,
    output logic signed [PIXEL_BITS-1:0]  image_y,
    output logic                          valid_res
);

    localparam logic signed [41:0] PIX_MAX =
        $signed((42'd1 << (PIXEL_BITS - 1)) - 42'd1);
    localparam logic signed [41:0] PIX_MIN = -PIX_MAX - 42'sd1;
    localparam logic [40:0]        Q_LIM   = {1'b1, 40'd0};

    //------------------------------------------------------------------
    // configuration registers
    //------------------------------------------------------------------
    logic [ppgp_pkg::ROT_W-1:0] rot_reg [3];
    logic [ppgp_pkg::TRN_W-1:0] tw2c_reg;
    logic [ppgp_pkg::TRN_W-1:0] tc2w_reg;
    logic [ppgp_pkg::CAM_W-1:0] focal_reg;
    logic [ppgp_pkg::CAM_W-1:0] ctr_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            rot_reg[0] <= ppgp_pkg::ROT0_RST;
            rot_reg[1] <= ppgp_pkg::ROT1_RST;
            rot_reg[2] <= ppgp_pkg::ROT2_RST;
            tw2c_reg   <= '0;
            tc2w_reg   <= '0;
            focal_reg  <= ppgp_pkg::FOCAL_RST;
            ctr_reg    <= ppgp_pkg::CTR_RST;
        end
        else if (cfg_we)
        begin
            case (cfg_index)
                ppgp_pkg::REG_ROT0:    rot_reg[0] <= cfg_data[ppgp_pkg::ROT_W-1:0];
                ppgp_pkg::REG_ROT1:    rot_reg[1] <= cfg_data[ppgp_pkg::ROT_W-1:0];
                ppgp_pkg::REG_ROT2:    rot_reg[2] <= cfg_data[ppgp_pkg::ROT_W-1:0];
                ppgp_pkg::REG_T_W2C:   tw2c_reg   <= cfg_data;
                ppgp_pkg::REG_T_C2W:   tc2w_reg   <= cfg_data;
                ppgp_pkg::REG_FOCAL:   focal_reg  <= cfg_data[ppgp_pkg::CAM_W-1:0];
                ppgp_pkg::REG_IMG_CTR: ctr_reg    <= cfg_data[ppgp_pkg::CAM_W-1:0];
                default: ;
            endcase
        end
    end

    // unpacked views of the pose and intrinsics
    logic signed [17:0] rot [3][3];
    logic signed [19:0] tw  [3];
    logic signed [19:0] tc  [3];
    logic [19:0]        fx, fy, cx, cy;
    logic signed [20:0] fx_s, fy_s, cx_s, cy_s;

    always_comb
    begin
        for (int r = 0; r < 3; r++)
        begin
            for (int c = 0; c < 3; c++)
            begin
                rot[r][c] = $signed(rot_reg[r][(53 - 18*c) -: 18]);
            end
            tw[r] = $signed(tw2c_reg[(59 - 20*r) -: 20]);
            tc[r] = $signed(tc2w_reg[(59 - 20*r) -: 20]);
        end
    end

    assign fx   = focal_reg[39:20];
    assign fy   = focal_reg[19:0];
    assign cx   = ctr_reg[39:20];
    assign cy   = ctr_reg[19:0];
    assign fx_s = $signed({1'b0, fx});
    assign fy_s = $signed({1'b0, fy});
    assign cx_s = $signed({1'b0, cx});
    assign cy_s = $signed({1'b0, cy});

    //------------------------------------------------------------------
    // pipe control: everything moves unless the output word is stalled
    //------------------------------------------------------------------
    logic adv;
    logic o_vld_reg;

    assign adv      = !o_vld_reg || !out_stall;
    assign in_stall = !adv;

    //------------------------------------------------------------------
    // stage A: centered pixel, rotated world terms
    //------------------------------------------------------------------
    logic               a_vld_reg;
    logic               a_kind_reg;
    logic signed [24:0] a_u_reg, a_v_reg;
    logic signed [37:0] a_rw_reg [3][3];

    logic signed [24:0] px_ext, py_ext;
    logic signed [19:0] w_in [3];

    assign px_ext  = $signed({{(25-PIXEL_BITS){pixel_x[PIXEL_BITS-1]}}, pixel_x});
    assign py_ext  = $signed({{(25-PIXEL_BITS){pixel_y[PIXEL_BITS-1]}}, pixel_y});
    assign w_in[0] = world_x;
    assign w_in[1] = world_y;
    assign w_in[2] = world_z;

    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            a_kind_reg <= kind;
            a_u_reg    <= (px_ext <<< 8) - $signed({5'd0, cx});
            a_v_reg    <= (py_ext <<< 8) - $signed({5'd0, cy});
            for (int r = 0; r < 3; r++)
            begin
                for (int j = 0; j < 3; j++)
                begin
                    a_rw_reg[r][j] <= rot[r][j] * w_in[j];
                end
            end
        end
    end

    //------------------------------------------------------------------
    // stage B: ray direction in the camera frame, camera-frame point
    //------------------------------------------------------------------
    logic               b_vld_reg;
    logic               b_kind_reg;
    logic               b_fnz_reg;
    logic signed [45:0] b_n_reg   [3];
    logic signed [41:0] b_cam_reg [3];
    logic [39:0]        ff;

    assign ff = fx * fy;

    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            b_kind_reg <= a_kind_reg;
            b_fnz_reg  <= (ff != 40'd0);
            b_n_reg[0] <= a_u_reg * fy_s;
            b_n_reg[1] <= a_v_reg * fx_s;
            b_n_reg[2] <= $signed({6'd0, ff});
            for (int r = 0; r < 3; r++)
            begin
                b_cam_reg[r] <= a_rw_reg[r][0] + a_rw_reg[r][1] + a_rw_reg[r][2]
                              + $signed({{6{tw[r][19]}}, tw[r], 16'd0});
            end
        end
    end

    //------------------------------------------------------------------
    // stage C: split products (wide operand cut in two halves)
    //------------------------------------------------------------------
    logic               c_vld_reg;
    logic               c_kind_reg;
    logic               c_fnz_reg;
    logic signed [41:0] c_plo_reg [3][3];
    logic signed [40:0] c_phi_reg [3][3];
    logic signed [42:0] c_mlo_reg [4];
    logic signed [41:0] c_mhi_reg [4];
    logic signed [41:0] c_cz_reg;

    logic signed [41:0] m_op [4];
    logic signed [20:0] m_f  [4];

    assign m_op[0] = b_cam_reg[0];
    assign m_op[1] = b_cam_reg[1];
    assign m_op[2] = b_cam_reg[2];
    assign m_op[3] = b_cam_reg[2];
    assign m_f[0]  = fx_s;
    assign m_f[1]  = fy_s;
    assign m_f[2]  = cx_s;
    assign m_f[3]  = cy_s;

    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            c_kind_reg <= b_kind_reg;
            c_fnz_reg  <= b_fnz_reg;
            c_cz_reg   <= b_cam_reg[2];
            for (int i = 0; i < 3; i++)
            begin
                for (int c = 0; c < 3; c++)
                begin
                    c_plo_reg[i][c] <= rot[i][c] * $signed({1'b0, b_n_reg[i][22:0]});
                    c_phi_reg[i][c] <= rot[i][c] * $signed(b_n_reg[i][45:23]);
                end
            end
            for (int k = 0; k < 4; k++)
            begin
                c_mlo_reg[k] <= $signed({1'b0, m_op[k][20:0]}) * m_f[k];
                c_mhi_reg[k] <= $signed(m_op[k][41:21]) * m_f[k];
            end
        end
    end

    //------------------------------------------------------------------
    // stage D: recombine partial products
    //------------------------------------------------------------------
    logic               d_vld_reg;
    logic               d_kind_reg;
    logic               d_fnz_reg;
    logic signed [65:0] d_p_reg [3][3];
    logic signed [65:0] d_m_reg [4];
    logic signed [41:0] d_cz_reg;

    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            d_kind_reg <= c_kind_reg;
            d_fnz_reg  <= c_fnz_reg;
            d_cz_reg   <= c_cz_reg;
            for (int i = 0; i < 3; i++)
            begin
                for (int c = 0; c < 3; c++)
                begin
                    d_p_reg[i][c] <=
                        $signed({{2{c_phi_reg[i][c][40]}}, c_phi_reg[i][c], 23'd0})
                      + $signed({{24{c_plo_reg[i][c][41]}}, c_plo_reg[i][c]});
                end
            end
            for (int k = 0; k < 4; k++)
            begin
                d_m_reg[k] <= $signed({{3{c_mhi_reg[k][41]}}, c_mhi_reg[k], 21'd0})
                            + $signed({{23{c_mlo_reg[k][42]}}, c_mlo_reg[k]});
            end
        end
    end

    //------------------------------------------------------------------
    // stage E: dividend bases and divisor for both kinds
    //   kind 0: x = S0, y = S1, d = S2 (ray through R transposed)
    //   kind 1: x = cam_x*fx + cx*cz, y likewise, d = 256*cz
    //------------------------------------------------------------------
    logic               e_vld_reg;
    logic               e_kind_reg;
    logic               e_nz_reg;
    logic signed [65:0] e_x_reg, e_y_reg, e_d_reg;

    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            e_kind_reg <= d_kind_reg;
            if (d_kind_reg)
            begin
                e_nz_reg <= 1'b1;
                e_x_reg  <= d_m_reg[0] + d_m_reg[2];
                e_y_reg  <= d_m_reg[1] + d_m_reg[3];
                e_d_reg  <= $signed({{16{d_cz_reg[41]}}, d_cz_reg, 8'd0});
            end
            else
            begin
                e_nz_reg <= d_fnz_reg;
                e_x_reg  <= d_p_reg[0][0] + d_p_reg[1][0] + d_p_reg[2][0];
                e_y_reg  <= d_p_reg[0][1] + d_p_reg[1][1] + d_p_reg[2][1];
                e_d_reg  <= d_p_reg[0][2] + d_p_reg[1][2] + d_p_reg[2][2];
            end
        end
    end

    //------------------------------------------------------------------
    // stage F: magnitudes and result signs; kind 0 scales by -tz
    //------------------------------------------------------------------
    logic        f_vld_reg;
    logic        f_kind_reg;
    logic        f_ok_reg;
    logic        f_xneg_reg, f_yneg_reg;
    logic [19:0] f_a_reg;
    logic [64:0] f_xm_reg, f_ym_reg, f_dm_reg;

    logic [65:0] x_abs, y_abs, d_abs;
    logic [19:0] tz_abs;
    logic        a_neg;

    assign x_abs  = e_x_reg[65] ? 66'(-e_x_reg) : 66'(e_x_reg);
    assign y_abs  = e_y_reg[65] ? 66'(-e_y_reg) : 66'(e_y_reg);
    assign d_abs  = e_d_reg[65] ? 66'(-e_d_reg) : 66'(e_d_reg);
    assign tz_abs = tc[2][19] ? 20'(-tc[2]) : 20'(tc[2]);
    // -tz is negative when tz is positive
    assign a_neg  = !tc[2][19] && (tc[2] != 20'sd0) && !e_kind_reg;

    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            f_kind_reg <= e_kind_reg;
            f_ok_reg   <= e_nz_reg && (e_d_reg != 66'sd0);
            f_xneg_reg <= a_neg ^ e_x_reg[65] ^ e_d_reg[65];
            f_yneg_reg <= a_neg ^ e_y_reg[65] ^ e_d_reg[65];
            f_a_reg    <= e_kind_reg ? 20'd1 : tz_abs;
            f_xm_reg   <= x_abs[64:0];
            f_ym_reg   <= y_abs[64:0];
            f_dm_reg   <= d_abs[64:0];
        end
    end

    //------------------------------------------------------------------
    // stage G: dividend partial products
    //------------------------------------------------------------------
    logic        g_vld_reg;
    logic        g_kind_reg;
    logic        g_ok_reg;
    logic        g_xneg_reg, g_yneg_reg;
    logic [51:0] g_xlo_reg, g_ylo_reg;
    logic [52:0] g_xhi_reg, g_yhi_reg;
    logic [64:0] g_dm_reg;

    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            g_kind_reg <= f_kind_reg;
            g_ok_reg   <= f_ok_reg;
            g_xneg_reg <= f_xneg_reg;
            g_yneg_reg <= f_yneg_reg;
            g_dm_reg   <= f_dm_reg;
            g_xlo_reg  <= f_a_reg * f_xm_reg[31:0];
            g_xhi_reg  <= f_a_reg * f_xm_reg[64:32];
            g_ylo_reg  <= f_a_reg * f_ym_reg[31:0];
            g_yhi_reg  <= f_a_reg * f_ym_reg[64:32];
        end
    end

    //------------------------------------------------------------------
    // stage H: full dividend magnitudes
    //------------------------------------------------------------------
    logic                       h_vld_reg;
    logic [ppgp_pkg::NUM_W-1:0] h_xnum_reg, h_ynum_reg;
    logic [ppgp_pkg::DEN_W-1:0] h_dm_reg;
    ppgp_pkg::side_t            h_xside_reg, h_yside_reg;

    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            h_xnum_reg  <= {g_xhi_reg, 32'd0} + {33'd0, g_xlo_reg};
            h_ynum_reg  <= {g_yhi_reg, 32'd0} + {33'd0, g_ylo_reg};
            h_dm_reg    <= g_dm_reg;
            h_xside_reg <= '{kind: g_kind_reg, ok: g_ok_reg, neg: g_xneg_reg};
            h_yside_reg <= '{kind: g_kind_reg, ok: g_ok_reg, neg: g_yneg_reg};
        end
    end

    // valid bits of stages A..H
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            a_vld_reg <= 1'b0;
            b_vld_reg <= 1'b0;
            c_vld_reg <= 1'b0;
            d_vld_reg <= 1'b0;
            e_vld_reg <= 1'b0;
            f_vld_reg <= 1'b0;
            g_vld_reg <= 1'b0;
            h_vld_reg <= 1'b0;
        end
        else if (adv)
        begin
            a_vld_reg <= in_valid;
            b_vld_reg <= a_vld_reg;
            c_vld_reg <= b_vld_reg;
            d_vld_reg <= c_vld_reg;
            e_vld_reg <= d_vld_reg;
            f_vld_reg <= e_vld_reg;
            g_vld_reg <= f_vld_reg;
            h_vld_reg <= g_vld_reg;
        end
    end

    //------------------------------------------------------------------
    // divider pair
    //------------------------------------------------------------------
    logic                        dx_vld, dy_vld;
    logic [ppgp_pkg::QUOT_W-1:0] dx_q, dy_q;
    logic                        dx_ovf, dy_ovf;
    ppgp_pkg::side_t             dx_side, dy_side;

    ppgp_div u_div_x (
        .clk      (clk),
        .rst_n    (rst_n),
        .adv      (adv),
        .in_vld   (h_vld_reg),
        .num      (h_xnum_reg),
        .den      (h_dm_reg),
        .side_in  (h_xside_reg),
        .out_vld  (dx_vld),
        .quot     (dx_q),
        .ovf      (dx_ovf),
        .side_out (dx_side)
    );

    ppgp_div u_div_y (
        .clk      (clk),
        .rst_n    (rst_n),
        .adv      (adv),
        .in_vld   (h_vld_reg),
        .num      (h_ynum_reg),
        .den      (h_dm_reg),
        .side_in  (h_yside_reg),
        .out_vld  (dy_vld),
        .quot     (dy_q),
        .ovf      (dy_ovf),
        .side_out (dy_side)
    );

    //------------------------------------------------------------------
    // output stage: clamp quotient, apply sign, offset and saturate
    //------------------------------------------------------------------
    logic [40:0]        qx_m, qy_m;
    logic signed [41:0] qx_s, qy_s;
    logic signed [42:0] gx_sum, gy_sum;
    logic signed [19:0] gx_next, gy_next;
    logic signed [PIXEL_BITS-1:0] ix_next, iy_next;
    logic               ok, kind_o;

    assign qx_m = (dx_ovf || dx_q > Q_LIM) ? Q_LIM : dx_q;
    assign qy_m = (dy_ovf || dy_q > Q_LIM) ? Q_LIM : dy_q;
    assign qx_s = dx_side.neg ? -$signed({1'b0, qx_m}) : $signed({1'b0, qx_m});
    assign qy_s = dy_side.neg ? -$signed({1'b0, qy_m}) : $signed({1'b0, qy_m});
    assign ok     = dx_side.ok && dy_side.ok;
    assign kind_o = dx_side.kind;

    assign gx_sum = $signed({{23{tc[0][19]}}, tc[0]}) + $signed({qx_s[41], qx_s});
    assign gy_sum = $signed({{23{tc[1][19]}}, tc[1]}) + $signed({qy_s[41], qy_s});

    always_comb
    begin
        gx_next = '0;
        gy_next = '0;
        ix_next = '0;
        iy_next = '0;
        if (ok && !kind_o)
        begin
            if (gx_sum > ppgp_pkg::GND_MAX)      gx_next = ppgp_pkg::GND_MAX[19:0];
            else if (gx_sum < ppgp_pkg::GND_MIN) gx_next = ppgp_pkg::GND_MIN[19:0];
            else                                 gx_next = gx_sum[19:0];
            if (gy_sum > ppgp_pkg::GND_MAX)      gy_next = ppgp_pkg::GND_MAX[19:0];
            else if (gy_sum < ppgp_pkg::GND_MIN) gy_next = ppgp_pkg::GND_MIN[19:0];
            else                                 gy_next = gy_sum[19:0];
        end
        else if (ok && kind_o)
        begin
            if (qx_s > PIX_MAX)      ix_next = PIX_MAX[PIXEL_BITS-1:0];
            else if (qx_s < PIX_MIN) ix_next = PIX_MIN[PIXEL_BITS-1:0];
            else                     ix_next = qx_s[PIXEL_BITS-1:0];
            if (qy_s > PIX_MAX)      iy_next = PIX_MAX[PIXEL_BITS-1:0];
            else if (qy_s < PIX_MIN) iy_next = PIX_MIN[PIXEL_BITS-1:0];
            else                     iy_next = qy_s[PIXEL_BITS-1:0];
        end
    end

    logic signed [19:0]           gx_reg, gy_reg;
    logic signed [PIXEL_BITS-1:0] ix_reg, iy_reg;
    logic                         vres_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            o_vld_reg <= 1'b0;
        end
        else if (adv)
        begin
            o_vld_reg <= dx_vld && dy_vld;
        end
    end

    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            gx_reg   <= gx_next;
            gy_reg   <= gy_next;
            ix_reg   <= ix_next;
            iy_reg   <= iy_next;
            vres_reg <= ok;
        end
    end

    assign out_valid = o_vld_reg;
    assign ground_x  = gx_reg;
    assign ground_y  = gy_reg;
    assign image_x   = ix_reg;
    assign image_y   = iy_reg;
    assign valid_res = vres_reg;

    //------------------------------------------------------------------
    // assertions
    //------------------------------------------------------------------
    a_accept_enters: assert property (@(posedge clk) disable iff (!rst_n)
        (in_valid && !in_stall) |=> a_vld_reg)
        else $error("accepted word did not enter the pipe");

    a_div_aligned: assert property (@(posedge clk) disable iff (!rst_n)
        dx_vld == dy_vld)
        else $error("x and y dividers out of step");

    a_invalid_zero: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid && !valid_res) |->
            (ground_x == 20'sd0 && ground_y == 20'sd0 &&
             image_x == '0 && image_y == '0))
        else $error("invalid result carries nonzero fields");

endmodule

@@ verif/pinhole_ground_plane_projection_tb.sv @@
`timescale 1ns / 1ps

module pinhole_ground_plane_projection_tb;

    localparam int PB = 13;
    localparam int PIPE_CYCLES = 60;   // margin over the block's pipe depth

    // one expected result word
    typedef struct {
        logic signed [19:0]   gx;
        logic signed [19:0]   gy;
        logic signed [PB-1:0] ix;
        logic signed [PB-1:0] iy;
        logic                 vr;
    } proj_t;

    // Mirror of the register file plus the in-order queue of projections
    // still owed by the block.
    class proj_scoreboard;
        logic [ppgp_pkg::CFG_W-1:0] regs [7];
        proj_t                      owed [$];
        int                         errs;

        function new();
            errs = 0;
            regs[ppgp_pkg::REG_ROT0]    = {6'd0, ppgp_pkg::ROT0_RST};
            regs[ppgp_pkg::REG_ROT1]    = {6'd0, ppgp_pkg::ROT1_RST};
            regs[ppgp_pkg::REG_ROT2]    = {6'd0, ppgp_pkg::ROT2_RST};
            regs[ppgp_pkg::REG_T_W2C]   = '0;
            regs[ppgp_pkg::REG_T_C2W]   = '0;
            regs[ppgp_pkg::REG_FOCAL]   = {20'd0, ppgp_pkg::FOCAL_RST};
            regs[ppgp_pkg::REG_IMG_CTR] = {20'd0, ppgp_pkg::CTR_RST};
        endfunction

        function logic signed [127:0] rot(int row, int col);
            logic [ppgp_pkg::CFG_W-1:0] r;
            r = regs[row];
            return $signed(r[53 - 18*col -: 18]);
        endfunction

        function logic signed [127:0] trn(int idx, int comp);
            logic [ppgp_pkg::CFG_W-1:0] r;
            r = regs[idx];
            return $signed(r[59 - 20*comp -: 20]);
        endfunction

        function logic signed [127:0] clip(logic signed [127:0] v,
                                           logic signed [127:0] lo,
                                           logic signed [127:0] hi);
            return v < lo ? lo : (v > hi ? hi : v);
        endfunction

        // trunc(a*b/d), magnitude held to 2^40
        function logic signed [127:0] scaled_quot(logic signed [127:0] a,
                                                  logic signed [127:0] b,
                                                  logic signed [127:0] d);
            logic signed [127:0] lim;
            lim = 128'sd1 <<< 40;
            return clip((a * b) / d, -lim, lim);
        endfunction

        function void note(logic k, logic signed [PB-1:0] px, logic signed [PB-1:0] py,
                           logic signed [19:0] wx, logic signed [19:0] wy,
                           logic signed [19:0] wz);
            logic signed [127:0] fx, fy, cx, cy, u, v, ntz, den;
            logic signed [127:0] n [3];
            logic signed [127:0] s [3];
            logic signed [127:0] w [3];
            logic signed [127:0] cam [3];
            logic signed [127:0] pmax, pmin;
            logic [ppgp_pkg::CFG_W-1:0] f, c;
            proj_t e;
            f = regs[ppgp_pkg::REG_FOCAL];
            c = regs[ppgp_pkg::REG_IMG_CTR];
            fx = {108'd0, f[39:20]};
            fy = {108'd0, f[19:0]};
            cx = {108'd0, c[39:20]};
            cy = {108'd0, c[19:0]};
            pmax = (128'sd1 <<< (PB-1)) - 1;
            pmin = -(128'sd1 <<< (PB-1));
            e = '{gx: '0, gy: '0, ix: '0, iy: '0, vr: 1'b0};
            if (k == ppgp_pkg::KIND_GROUND) begin
                u = px; u = u * 256 - cx;
                v = py; v = v * 256 - cy;
                n[0] = u * fy;
                n[1] = v * fx;
                n[2] = fx * fy;
                // ray direction: columns of R, i.e. R transposed times n
                for (int cc = 0; cc < 3; cc++) begin
                    s[cc] = 0;
                    for (int i = 0; i < 3; i++) s[cc] += rot(i, cc) * n[i];
                end
                if (fx != 0 && fy != 0 && s[2] != 0) begin
                    ntz = -trn(ppgp_pkg::REG_T_C2W, 2);
                    e.gx = 20'(clip(trn(ppgp_pkg::REG_T_C2W, 0)
                                    + scaled_quot(ntz, s[0], s[2]),
                                    -128'sd524288, 128'sd524287));
                    e.gy = 20'(clip(trn(ppgp_pkg::REG_T_C2W, 1)
                                    + scaled_quot(ntz, s[1], s[2]),
                                    -128'sd524288, 128'sd524287));
                    e.vr = 1'b1;
                end
            end else begin
                w[0] = wx; w[1] = wy; w[2] = wz;
                for (int r = 0; r < 3; r++) begin
                    cam[r] = trn(ppgp_pkg::REG_T_W2C, r) * 65536;
                    for (int j = 0; j < 3; j++) cam[r] += rot(r, j) * w[j];
                end
                if (cam[2] != 0) begin
                    den = cam[2] * 256;
                    e.ix = PB'(clip((cam[0] * fx + cx * cam[2]) / den, pmin, pmax));
                    e.iy = PB'(clip((cam[1] * fy + cy * cam[2]) / den, pmin, pmax));
                    e.vr = 1'b1;
                end
            end
            owed = {owed, e};
        endfunction

        function void check(proj_t got);
            proj_t e;
            if (owed.size() == 0) begin
                $display("%0t: unexpected result word gx=%0d gy=%0d ix=%0d iy=%0d v=%0b",
                         $realtime, got.gx, got.gy, got.ix, got.iy, got.vr);
                errs++;
                return;
            end
            e = owed.pop_front();
            if (got.gx !== e.gx) begin
                $display("%0t: ground_x expected %0d actual %0d", $realtime, e.gx, got.gx);
                errs++;
            end
            if (got.gy !== e.gy) begin
                $display("%0t: ground_y expected %0d actual %0d", $realtime, e.gy, got.gy);
                errs++;
            end
            if (got.ix !== e.ix) begin
                $display("%0t: image_x expected %0d actual %0d", $realtime, e.ix, got.ix);
                errs++;
            end
            if (got.iy !== e.iy) begin
                $display("%0t: image_y expected %0d actual %0d", $realtime, e.iy, got.iy);
                errs++;
            end
            if (got.vr !== e.vr) begin
                $display("%0t: valid_res expected %0b actual %0b", $realtime, e.vr, got.vr);
                errs++;
            end
        endfunction
    endclass

    logic                       clk = 1'b0;
    logic                       rst_n = 1'b0;
    logic                       cfg_we = 1'b0;
    logic [2:0]                 cfg_index = ppgp_pkg::REG_ROT0;
    logic [ppgp_pkg::CFG_W-1:0] cfg_data = '0;
    logic                       in_valid = 1'b0;
    logic                       in_stall;
    logic                       kind = ppgp_pkg::KIND_GROUND;
    logic signed [PB-1:0]       pixel_x = '0;
    logic signed [PB-1:0]       pixel_y = '0;
    logic signed [19:0]         world_x = '0;
    logic signed [19:0]         world_y = '0;
    logic signed [19:0]         world_z = '0;
    logic                       out_valid;
    logic                       out_stall = 1'b0;
    logic signed [19:0]         ground_x;
    logic signed [19:0]         ground_y;
    logic signed [PB-1:0]       image_x;
    logic signed [PB-1:0]       image_y;
    logic                       valid_res;

    bit idle_en = 1'b1;   // random gaps on both sides; cleared for the tail
    int stall_left = 0;

    proj_scoreboard sb = new();

    pinhole_ground_plane_projection #(.PIXEL_BITS(PB)) u_top (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .in_valid  (in_valid),
        .in_stall  (in_stall),
        .kind      (kind),
        .pixel_x   (pixel_x),
        .pixel_y   (pixel_y),
        .world_x   (world_x),
        .world_y   (world_y),
        .world_z   (world_z),
        .out_valid (out_valid),
        .out_stall (out_stall),
        .ground_x  (ground_x),
        .ground_y  (ground_y),
        .image_x   (image_x),
        .image_y   (image_y),
        .valid_res (valid_res)
    );

    always
    begin
        #6 clk = 1'b1;
        #6 clk = 1'b0;
    end

    // output side: random bursts of stalled cycles
    always @(posedge clk)
    begin
        if (!idle_en) begin
            out_stall <= 1'b0;
            stall_left <= 0;
        end else if (stall_left > 0) begin
            out_stall <= 1'b1;
            stall_left <= stall_left - 1;
        end else if ($urandom_range(0, 5) == 0) begin
            out_stall <= 1'b1;
            stall_left <= $urandom_range(0, 7);
        end else begin
            out_stall <= 1'b0;
        end
    end

    // every word leaving the block is checked against the oldest projection
    always @(posedge clk)
    begin
        if (rst_n && out_valid && !out_stall)
            sb.check('{gx: ground_x, gy: ground_y, ix: image_x, iy: image_y, vr: valid_res});
    end

    initial
    begin
        #2_000_000;
        $display("Simulation FAILED");
        $finish;
    end

    // wait for the pipe to drain before touching registers
    task automatic drain();
        in_valid <= 1'b0;
        while (sb.owed.size() != 0) @(posedge clk);
        repeat (PIPE_CYCLES) @(posedge clk);
    endtask

    task automatic write_reg(logic [2:0] idx, logic [ppgp_pkg::CFG_W-1:0] data);
        cfg_we    <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= data;
        @(posedge clk);
        cfg_we <= 1'b0;
        case (idx)
            ppgp_pkg::REG_ROT0, ppgp_pkg::REG_ROT1, ppgp_pkg::REG_ROT2:
                sb.regs[idx] = data & {6'd0, {ppgp_pkg::ROT_W{1'b1}}};
            ppgp_pkg::REG_T_W2C, ppgp_pkg::REG_T_C2W:
                sb.regs[idx] = data & {ppgp_pkg::TRN_W{1'b1}};
            default:
                sb.regs[idx] = data & {20'd0, {ppgp_pkg::CAM_W{1'b1}}};
        endcase
    endtask

    task automatic write_all(logic [ppgp_pkg::CFG_W-1:0] r0, logic [ppgp_pkg::CFG_W-1:0] r1,
                             logic [ppgp_pkg::CFG_W-1:0] r2, logic [ppgp_pkg::CFG_W-1:0] tw,
                             logic [ppgp_pkg::CFG_W-1:0] tc, logic [ppgp_pkg::CFG_W-1:0] fl,
                             logic [ppgp_pkg::CFG_W-1:0] ct);
        drain();
        write_reg(ppgp_pkg::REG_ROT0, r0);
        write_reg(ppgp_pkg::REG_ROT1, r1);
        write_reg(ppgp_pkg::REG_ROT2, r2);
        write_reg(ppgp_pkg::REG_T_W2C, tw);
        write_reg(ppgp_pkg::REG_T_C2W, tc);
        write_reg(ppgp_pkg::REG_FOCAL, fl);
        write_reg(ppgp_pkg::REG_IMG_CTR, ct);
    endtask

    // one word on the input channel; optional gap before it
    task automatic send(logic k, logic signed [PB-1:0] px, logic signed [PB-1:0] py,
                        logic signed [19:0] wx, logic signed [19:0] wy,
                        logic signed [19:0] wz);
        if (idle_en && $urandom_range(0, 4) == 0) begin
            in_valid <= 1'b0;
            repeat ($urandom_range(1, 8)) @(posedge clk);
        end
        in_valid <= 1'b1;
        kind     <= k;
        pixel_x  <= px;
        pixel_y  <= py;
        world_x  <= wx;
        world_y  <= wy;
        world_z  <= wz;
        do @(posedge clk); while (in_stall);
        sb.note(k, px, py, wx, wy, wz);
    endtask

    task automatic send_random();
        logic signed [PB-1:0] px, py;
        logic signed [19:0]   wx, wy, wz;
        if ($urandom_range(0, 1)) begin
            px = PB'($urandom);
            py = PB'($urandom);
        end else begin
            // mostly inside a VGA-sized frame
            px = PB'($urandom_range(0, 639));
            py = PB'($urandom_range(0, 479));
        end
        if ($urandom_range(0, 1)) begin
            wx = 20'($urandom);
            wy = 20'($urandom);
            wz = 20'($urandom);
        end else begin
            wx = $signed(20'($urandom_range(0, 65535))) - 20'sd32768;
            wy = $signed(20'($urandom_range(0, 65535))) - 20'sd32768;
            wz = $signed(20'($urandom_range(0, 8191))) - 20'sd4096;
        end
        send(1'($urandom_range(0, 1)), px, py, wx, wy, wz);
    endtask

    function automatic logic [ppgp_pkg::CFG_W-1:0] rnd60();
        logic [63:0] t;
        t = {$urandom, $urandom};
        return t[ppgp_pkg::CFG_W-1:0];
    endfunction

    localparam logic [17:0] ONE  = 18'h10000;
    localparam logic [17:0] MONE = 18'h30000;

    initial
    begin
        logic [19:0] h;
        repeat (6) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // directed, reset pose: centre pixel, frame corners, field extremes
        send(ppgp_pkg::KIND_GROUND, 13'sd320, 13'sd240, '0, '0, '0);
        send(ppgp_pkg::KIND_GROUND, -13'sd4096, -13'sd4096, '0, '0, '0);
        send(ppgp_pkg::KIND_GROUND, 13'sd4095, 13'sd4095, '0, '0, '0);
        send(ppgp_pkg::KIND_GROUND, 13'sd0, 13'sd4095, '0, '0, '0);
        send(ppgp_pkg::KIND_IMAGE, '0, '0, 20'sd0, 20'sd0, 20'sd0);   // zero depth
        send(ppgp_pkg::KIND_IMAGE, '0, '0, 20'sd4096, 20'sd4096, 20'sd4096);
        send(ppgp_pkg::KIND_IMAGE, '0, '0, 20'sd524287, 20'sd524287, 20'sd1);   // saturates
        send(ppgp_pkg::KIND_IMAGE, '0, '0, -20'sd524288, -20'sd524288, 20'sd1);
        send(ppgp_pkg::KIND_IMAGE, '0, '0, -20'sd524288, 20'sd524287, -20'sd524288);
        send(ppgp_pkg::KIND_IMAGE, 13'sd4095, -13'sd4096, 20'sd1, -20'sd1, -20'sd4096);

        // downward camera two metres up: ray meets ground
        write_all({6'd0, ONE, 18'd0, 18'd0}, {6'd0, 18'd0, MONE, 18'd0},
                  {6'd0, 18'd0, 18'd0, MONE},
                  {20'd0, 20'd0, 20'd8192}, {20'd4096, -20'sd4096, 20'd8192},
                  {20'd0, ppgp_pkg::FOCAL_RST}, {20'd0, ppgp_pkg::CTR_RST});
        send(ppgp_pkg::KIND_GROUND, 13'sd320, 13'sd240, '0, '0, '0);
        send(ppgp_pkg::KIND_GROUND, 13'sd0, 13'sd0, '0, '0, '0);
        send(ppgp_pkg::KIND_GROUND, -13'sd4096, 13'sd4095, '0, '0, '0);
        send(ppgp_pkg::KIND_IMAGE, '0, '0, 20'sd4096, 20'sd4096, 20'sd0);
        send(ppgp_pkg::KIND_IMAGE, '0, '0, 20'sd0, 20'sd0, 20'sd8192);   // at camera depth

        // all ones, then all zeros (zero focal lengths)
        write_all('1, '1, '1, '1, '1, '1, '1);
        send(ppgp_pkg::KIND_GROUND, 13'sd4095, -13'sd4096, '0, '0, '0);
        send(ppgp_pkg::KIND_IMAGE, '0, '0, 20'sd524287, -20'sd524288, 20'sd524287);
        send(ppgp_pkg::KIND_GROUND, 13'sd1, 13'sd1, '0, '0, '0);
        write_all('0, '0, '0, '0, '0, '0, '0);
        send(ppgp_pkg::KIND_GROUND, 13'sd100, 13'sd100, '0, '0, '0);
        send(ppgp_pkg::KIND_IMAGE, '0, '0, 20'sd4096, 20'sd4096, 20'sd4096);
        // flat camera: ray parallel to ground
        write_all({6'd0, ONE, 18'd0, 18'd0}, {6'd0, 18'd0, 18'd0, MONE},
                  {6'd0, 18'd0, ONE, 18'd0},
                  '0, {40'd0, 20'd8192},
                  {20'd0, ppgp_pkg::FOCAL_RST}, {20'd0, ppgp_pkg::CTR_RST});
        send(ppgp_pkg::KIND_GROUND, 13'sd320, 13'sd240, '0, '0, '0);
        send(ppgp_pkg::KIND_GROUND, 13'sd320, 13'sd100, '0, '0, '0);

        // random phases: realistic downward poses and raw random registers
        for (int ph = 0; ph < 10; ph++) begin
            if (ph % 2 == 0) begin
                h = 20'($urandom_range(1, 40000));
                write_all({6'd0, ONE - 18'($urandom_range(0, 2000)),
                           18'($urandom_range(0, 4000)), 18'($urandom_range(0, 4000))},
                          {6'd0, 18'($urandom_range(0, 4000)), MONE,
                           18'($urandom_range(0, 4000))},
                          {6'd0, 18'($urandom_range(0, 4000)),
                           18'($urandom_range(0, 4000)), MONE},
                          {rnd60()} & 60'h0000F_0000F_FFFFF, {40'($urandom), h},
                          {20'd0, 20'($urandom_range(1, 1048575)),
                           20'($urandom_range(1, 1048575))},
                          {20'd0, 20'($urandom_range(0, 300000)),
                           20'($urandom_range(0, 300000))});
            end else begin
                write_all(rnd60(), rnd60(), rnd60(), rnd60(), rnd60(), rnd60(), rnd60());
            end
            for (int i = 0; i < 100; i++) begin
                if (ph == 9 && i == 40) idle_en = 1'b0;
                send_random();
            end
        end
        in_valid <= 1'b0;

        while (sb.owed.size() != 0) @(posedge clk);
        repeat (PIPE_CYCLES) @(posedge clk);
        if (sb.errs == 0)
            $display("Simulation PASSED");
        else
            $display("Simulation FAILED");
        $finish;
    end

endmodule
